@@ rtl/i2c_mbe_pkg.sv @@
// shared types and codes for the i2c master byte engine
package i2c_mbe_pkg;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_STOP  = 3'd4;

  localparam logic [3:0] ACK_SLOT  = 4'd8;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_STOP  = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       hdr;
    logic [1:0] pre;
    logic [3:0] slot;
    logic [1:0] sub;
    logic [7:0] shift;
    logic [7:0] rx;
    logic       ack;
    logic       scl;
    logic       sda;
    logic       nack;
  } eng_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
    logic       rej;
  } res_t;

endpackage

@@ rtl/i2c_mbe_step.sv @@
// next state and result of the engine for one item
module i2c_mbe_step (
  input  i2c_mbe_pkg::eng_state_t cur,
  input  logic [2:0]              req_type,
  input  logic [6:0]              slave_address,
  input  logic                    read_not_write,
  input  logic [7:0]              tx_byte,
  input  logic                    master_nack,
  input  logic                    sda_in,
  output i2c_mbe_pkg::eng_state_t nxt,
  output i2c_mbe_pkg::res_t       res
);

  logic is_cmd;
  logic idle;
  logic fin;
  logic reading;

  always_comb begin
    is_cmd  = (req_type == i2c_mbe_pkg::REQ_START) || (req_type == i2c_mbe_pkg::REQ_WRITE) ||
              (req_type == i2c_mbe_pkg::REQ_READ) || (req_type == i2c_mbe_pkg::REQ_STOP);
    idle    = (cur.op == i2c_mbe_pkg::OP_IDLE);
    reading = (cur.op == i2c_mbe_pkg::OP_READ);
    fin     = 1'b0;
    nxt     = cur;
    res.rej = 1'b0;

    if (is_cmd) begin
      if (!idle) begin
        res.rej = 1'b1;
      end else begin
        nxt.op   = i2c_mbe_pkg::op_t'(req_type);
        nxt.hdr  = (req_type == i2c_mbe_pkg::REQ_START);
        nxt.pre  = 2'd0;
        nxt.slot = 4'd0;
        nxt.sub  = 2'd0;
        case (req_type)
          i2c_mbe_pkg::REQ_START: nxt.shift = {slave_address, read_not_write};
          i2c_mbe_pkg::REQ_WRITE: nxt.shift = tx_byte;
          i2c_mbe_pkg::REQ_READ: begin
            nxt.shift = 8'd0;
            nxt.nack  = master_nack;
          end
          default: ;
        endcase
      end
    end else if (!idle) begin
      if (cur.op == i2c_mbe_pkg::OP_STOP) begin
        case (cur.pre)
          2'd0: nxt.scl = 1'b0;
          2'd1: nxt.sda = 1'b0;
          2'd2: nxt.scl = 1'b1;
          default: begin
            nxt.sda = 1'b1;
            fin     = 1'b1;
          end
        endcase
        nxt.pre = cur.pre + 2'd1;
      end else if (cur.hdr) begin
        // start condition ahead of the address byte
        case (cur.pre)
          2'd0: nxt.sda = 1'b1;
          2'd1: nxt.scl = 1'b1;
          2'd2: nxt.sda = 1'b0;
          default: begin
            nxt.scl = 1'b0;
            nxt.hdr = 1'b0;
          end
        endcase
        nxt.pre = cur.pre + 2'd1;
      end else begin
        if (cur.slot != i2c_mbe_pkg::ACK_SLOT) begin
          case (cur.sub)
            2'd0: nxt.sda = reading ? 1'b1 : cur.shift[7];
            2'd1: begin
              nxt.scl = 1'b1;
              if (reading) nxt.shift = {cur.shift[6:0], sda_in};
            end
            default: begin
              nxt.scl = 1'b0;
              if (!reading) nxt.shift = {cur.shift[6:0], 1'b0};
            end
          endcase
        end else begin
          case (cur.sub)
            2'd0: nxt.sda = reading ? cur.nack : 1'b1;
            2'd1: begin
              nxt.scl = 1'b1;
              if (!reading) nxt.ack = ~sda_in;
            end
            default: begin
              nxt.scl = 1'b0;
              fin     = 1'b1;
              if (reading) nxt.rx = cur.shift;
            end
          endcase
        end
        if (cur.sub == 2'd2) begin
          nxt.sub  = 2'd0;
          nxt.slot = cur.slot + 4'd1;
        end else begin
          nxt.sub = cur.sub + 2'd1;
        end
      end
      if (fin) begin
        nxt.op   = i2c_mbe_pkg::OP_IDLE;
        nxt.pre  = 2'd0;
        nxt.slot = 4'd0;
        nxt.sub  = 2'd0;
      end
    end

    res.scl  = nxt.scl;
    res.sda  = nxt.sda;
    res.busy = (nxt.op != i2c_mbe_pkg::OP_IDLE);
    res.done = fin;
    res.rx   = nxt.rx;
    res.ack  = nxt.ack;
  end

endmodule

@@ rtl/i2c_master_byte_engine.sv @@
// top level of the i2c master byte engine with output register and skid stage
// usage:
//   the input channel carries one request per item: a tick, or a start, write,
//   read or stop command. a command is taken only while the engine is idle,
//   otherwise it is dropped and its result carries rejected. every tick after a
//   command moves scl or sda by one phase, or samples sda_in with scl high.
//   each input item yields exactly one result item on the output channel with
//   the line levels after that item, busy, done, the last read byte and ack.
//   results are registered in the output register; one item is taken every
//   cycle while in_stall is low, set by the one state register update per item.
//   a start takes 31 ticks, a write or read 27, a stop 4.
//   when the receiver stalls, results wait in the output register and a
//   skid register, so one more item is taken; in_stall rises only once the
//   skid register holds a result.
//   reset (rst_n low, synchronous) returns to idle with scl and sda released,
//   ack and received byte cleared, and empties both result registers.
module i2c_master_byte_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [6:0] in_slave_address,
  input  logic       in_read_not_write,
  input  logic [7:0] in_tx_byte,
  input  logic       in_master_nack,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_ack_received,
  output logic       out_rejected
);

  i2c_mbe_pkg::eng_state_t st_r;
  i2c_mbe_pkg::eng_state_t st_nxt;
  i2c_mbe_pkg::res_t       res;
  i2c_mbe_pkg::res_t       out_res_r;
  i2c_mbe_pkg::res_t       skid_res_r;
  logic                    out_valid_r;
  logic                    skid_valid_r;
  logic                    in_acc;
  logic                    out_free;

  i2c_mbe_step u_step (
    .cur            (st_r),
    .req_type       (in_req_type),
    .slave_address  (in_slave_address),
    .read_not_write (in_read_not_write),
    .tx_byte        (in_tx_byte),
    .master_nack    (in_master_nack),
    .sda_in         (in_sda_in),
    .nxt            (st_nxt),
    .res            (res)
  );

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.op      <= i2c_mbe_pkg::OP_IDLE;
      st_r.hdr     <= 1'b0;
      st_r.pre     <= 2'd0;
      st_r.slot    <= 4'd0;
      st_r.sub     <= 2'd0;
      st_r.shift   <= 8'd0;
      st_r.rx      <= 8'd0;
      st_r.ack     <= 1'b0;
      st_r.scl     <= 1'b1;
      st_r.sda     <= 1'b1;
      st_r.nack    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) st_r <= st_nxt;
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end
    if (!out_free && in_acc) begin
      skid_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_out      = out_res_r.scl;
  assign out_sda_out      = out_res_r.sda;
  assign out_busy_res     = out_res_r.busy;
  assign out_done_res     = out_res_r.done;
  assign out_rx_byte      = out_res_r.rx;
  assign out_ack_received = out_res_r.ack;
  assign out_rejected     = out_res_r.rej;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_rej_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res.rej |-> st_r.op != i2c_mbe_pkg::OP_IDLE)
    else $error("command rejected while idle");

  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && st_r.op == i2c_mbe_pkg::OP_IDLE &&
    (in_req_type == i2c_mbe_pkg::REQ_START || in_req_type == i2c_mbe_pkg::REQ_WRITE ||
     in_req_type == i2c_mbe_pkg::REQ_READ || in_req_type == i2c_mbe_pkg::REQ_STOP)
    |=> st_r.op != i2c_mbe_pkg::OP_IDLE)
    else $error("accepted command did not leave idle");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.sub != 2'd3 && st_r.slot <= i2c_mbe_pkg::ACK_SLOT)
    else $error("bit slot counters out of range");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res.done |=> st_r.op == i2c_mbe_pkg::OP_IDLE)
    else $error("engine still busy after done");

endmodule
